// ----- design/xpbd_pkg.sv -----
`timescale 1ns / 1ps

package xpbd_pkg;

	localparam int PARTICLES = 64;
	localparam int IDX_W     = $clog2(PARTICLES);

	localparam int S_TDATA_W = 272;
	localparam int M_TDATA_W = 128;

	// action codes
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_SOLVE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// status codes
	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_SOLVED    = 3'd1;
	localparam logic [2:0] ST_NOT_EVAL  = 3'd2;
	localparam logic [2:0] ST_ZERO_WGT  = 3'd3;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd4;

	// one particle row: position low, then mass, flags on top
	typedef struct packed {
		logic [1:0]        flags;
		logic [31:0]       mass;
		logic [2:0][31:0]  pos;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// request to the shared divider
	typedef struct packed {
		logic        start;
		logic [63:0] rem_init;
		logic [31:0] low;
		logic [63:0] divisor;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -50'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// ----- design/xpbd_distance_constraint_solver_unit.sv -----
`timescale 1ns / 1ps

// XPBD distance constraint unit over a table of 64 particles kept in one
// single-port synchronous row memory (position, inverse mass, flags). Items
// are handled one at a time. A solve uses one shared 32-step restoring
// divider (used for alpha, the multiplier step and the three per-axis
// corrections) and a 33-step square root, with a single 33x33 multiplier
// between them. A new beat is taken as soon as the unit is back in idle,
// even while the previous result still waits on the master side. Flag reads
// of rows never loaded return zero (not evaluated) through per-row valid
// bits cleared by reset; no clearing pass is needed.
module xpbd_distance_constraint_solver_unit
	import xpbd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// step_time, unsigned Q0.32
	input  logic                 step_time_we,
	input  logic [31:0]          step_time_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// index_a[5:0] index_b[11:6] rest_length[42:12] stretch_compliance[74:43]
	// shrink_compliance[106:75] lambda[138:107] pos_x[170:139] pos_y[202:171]
	// pos_z[234:203] inverse_mass[266:235] particle_flags[268:267], zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// action[1:0]
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// new_lambda[31:0] out_x[63:32] out_y[95:64] out_z[127:96]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [2:0]           m_axis_tuser
);

	localparam logic [10:0] PART_LIM = 11'(PARTICLES);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_READ, S_RDB, S_CHECK, S_SQ_MUL, S_SQ_ACC, S_DT_MUL,
		S_SQRT, S_CSEL, S_ALPHA, S_ALPHA_WAIT, S_LAM_MUL, S_LAM_USE, S_DL_GO,
		S_DL_WAIT, S_DL_FIX, S_CM_MUL, S_CM_GO, S_CM_WAIT, S_MV_A, S_MV_AU,
		S_MV_B, S_MV_BU, S_WR_A, S_WR_B, S_OUT
	} state_t;

	state_t state_q;

	// step time register
	logic [31:0] dt_q;

	// captured beat
	logic [1:0]         act_q;
	logic [5:0]         ia_q, ib_q;
	logic [30:0]        rest_q;
	logic [31:0]        str_q, shr_q;
	logic signed [31:0] lam_q;
	logic [31:0]        px_q, py_q, pz_q, im_q;
	logic [1:0]         pf_q;

	// flag valid bits, one per row
	logic [PARTICLES-1:0] fvalid_q;

	// solve working registers
	row_t                row_a_q, row_b_q;
	logic [31:0]         wa_q, wb_q;
	logic [32:0]         wsum_q;
	logic signed [32:0]  dlt_q [3];
	logic [1:0]          k_q;
	logic [65:0]         sum_q;
	logic signed [65:0]  prod_q;
	logic [63:0]         dsq_q;
	logic [32:0]         d_q;
	logic signed [34:0]  c_q;
	logic [31:0]         comp_q;
	logic [31:0]         alpha_q;
	logic [50:0]         nmag_q;
	logic                nneg_q;
	logic [33:0]         den_q;
	logic                qbig_q;
	logic [31:0]         quo_q;
	logic signed [31:0]  dl_q;
	logic [31:0]         corr_q;

	// result staging and output register
	logic [2:0]          res_status_q;
	logic signed [31:0]  res_lam_q;
	logic [2:0][31:0]    res_pos_q;
	logic                m_valid_q;
	logic [2:0]          m_status_q;
	logic [M_TDATA_W-1:0] m_data_q;

	// memory port
	logic             ram_we;
	logic [IDX_W-1:0] ram_addr;
	row_t             ram_wdata;
	row_t             ram_rdata;
	logic [ROW_W-1:0] ram_rdata_raw;

	// shared units
	div_req_t    div_req;
	logic        div_done;
	logic [31:0] div_quo;
	logic        sqrt_start;
	logic        sqrt_done;
	logic [32:0] sqrt_root;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	function automatic logic idx_ok(input logic [5:0] idx);
		return 11'(idx) < PART_LIM;
	endfunction

	xpbd_ram #(
		.DEPTH (PARTICLES),
		.WIDTH (ROW_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = row_t'(ram_rdata_raw);

	xpbd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	xpbd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (sum_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// ---------------------------------------------------------------
	// combinational helpers
	// ---------------------------------------------------------------
	logic [1:0]  fa_w, fb_w;
	logic [31:0] wa_w, wb_w;
	logic [32:0] wsum_w;
	logic signed [34:0] c_w;
	logic signed [50:0] num_w;
	logic signed [50:0] lamterm_w;
	logic [34:0] top_w;
	logic [32:0] qx_w;
	logic signed [31:0] dl_w;
	logic [32:0] magd_w;
	logic [31:0] magdl_w;
	logic [47:0] mv_w;
	logic        neg_a_w;
	logic        neg_w;
	logic [31:0] old_pos_w;
	logic signed [49:0] new_pos_w;
	logic signed [31:0] new_lam_w;

	// flags of a row never loaded read as zero
	assign fa_w   = fvalid_q[IDX_W'(ia_q)] ? row_a_q.flags : 2'b00;
	assign fb_w   = fvalid_q[IDX_W'(ib_q)] ? ram_rdata.flags : 2'b00;
	assign wa_w   = fa_w[1] ? row_a_q.mass : 32'd0;
	assign wb_w   = fb_w[1] ? ram_rdata.mass : 32'd0;
	assign wsum_w = {1'b0, wa_w} + {1'b0, wb_w};

	// constraint value, Q16.16
	assign c_w = $signed({2'b00, d_q}) - $signed({4'b0000, rest_q});

	// -c - floor(alpha * lambda / 2^16)
	assign lamterm_w = 51'(prod_q >>> 16);
	assign num_w     = -51'(c_q) - lamterm_w;

	// high part of the dividend for the multiplier step
	assign top_w = nmag_q[50:16];

	// saturate the step to signed 32 bits
	assign qx_w = qbig_q ? 33'h1_0000_0000 : {1'b0, quo_q};
	always_comb begin
		if (nneg_q) begin
			dl_w = (qx_w > 33'h0_8000_0000) ? 32'sh80000000 : 32'(-qx_w);
		end else begin
			dl_w = (qx_w > 33'h0_7fff_ffff) ? 32'sh7fffffff : qx_w[31:0];
		end
	end

	assign magd_w  = dlt_q[k_q][32] ? 33'(-dlt_q[k_q]) : dlt_q[k_q];
	assign magdl_w = dl_q[31] ? 32'(-dl_q) : dl_q;

	// move along the axis: a goes with the correction, b against it
	assign mv_w      = prod_q[63:16];
	assign neg_a_w   = dlt_q[k_q][32] ^ dl_q[31];
	assign neg_w     = (state_q == S_MV_AU) ? neg_a_w : !neg_a_w;
	assign old_pos_w = (state_q == S_MV_AU) ? row_a_q.pos[k_q] : row_b_q.pos[k_q];
	assign new_pos_w = neg_w ? (50'(signed'(old_pos_w)) - $signed({2'b00, mv_w}))
	                         : (50'(signed'(old_pos_w)) + $signed({2'b00, mv_w}));

	assign new_lam_w = sat32(50'(lam_q) + 50'(dl_q));

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_SQ_MUL: begin
				mul_a = dlt_q[k_q];
				mul_b = dlt_q[k_q];
			end
			S_DT_MUL: begin
				mul_a = {1'b0, dt_q};
				mul_b = {1'b0, dt_q};
			end
			S_LAM_MUL: begin
				mul_a = {1'b0, alpha_q};
				mul_b = {lam_q[31], lam_q};
			end
			S_CM_MUL: begin
				mul_a = {1'b0, magd_w[31:0]};
				mul_b = {1'b0, magdl_w};
			end
			S_MV_A: begin
				mul_a = {1'b0, corr_q};
				mul_b = {1'b0, wa_q};
			end
			S_MV_B: begin
				mul_a = {1'b0, corr_q};
				mul_b = {1'b0, wb_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			S_ALPHA: begin
				// comp * 2^52 / dt^2, quotient known below 2^32
				div_req.start    = (comp_q != 32'd0) && (dsq_q != 64'd0)
				                && ({12'd0, comp_q, 20'd0} < dsq_q);
				div_req.rem_init = {12'd0, comp_q, 20'd0};
				div_req.low      = 32'd0;
				div_req.divisor  = dsq_q;
			end
			S_DL_GO: begin
				div_req.start    = top_w < {1'b0, den_q};
				div_req.rem_init = 64'(top_w);
				div_req.low      = {nmag_q[15:0], 16'd0};
				div_req.divisor  = 64'(den_q);
			end
			S_CM_GO: begin
				div_req.start    = 1'b1;
				div_req.rem_init = {32'd0, prod_q[63:32]};
				div_req.low      = prod_q[31:0];
				div_req.divisor  = 64'(d_q);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	assign sqrt_start = (state_q == S_DT_MUL);

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = IDX_W'(ia_q);
		ram_wdata = row_a_q;
		case (state_q)
			S_DISP: begin
				ram_we          = (act_q == ACT_LOAD) && idx_ok(ia_q);
				ram_wdata.flags = pf_q;
				ram_wdata.mass  = im_q;
				ram_wdata.pos   = {pz_q, py_q, px_q};
			end
			S_RDB: begin
				ram_addr = IDX_W'(ib_q);
			end
			S_WR_A: begin
				ram_we = 1'b1;
			end
			S_WR_B: begin
				ram_we    = 1'b1;
				ram_addr  = IDX_W'(ib_q);
				ram_wdata = row_b_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			dt_q      <= 32'd71582788;
			fvalid_q  <= '0;
			m_valid_q <= 1'b0;
			k_q       <= '0;
		end else begin
			if (step_time_we) begin
				dt_q <= step_time_wdata;
			end
			// in S_OUT the output register is reloaded below instead
			if (m_valid_q && m_axis_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						act_q   <= s_axis_tuser;
						ia_q    <= s_axis_tdata[5:0];
						ib_q    <= s_axis_tdata[11:6];
						rest_q  <= s_axis_tdata[42:12];
						str_q   <= s_axis_tdata[74:43];
						shr_q   <= s_axis_tdata[106:75];
						lam_q   <= s_axis_tdata[138:107];
						px_q    <= s_axis_tdata[170:139];
						py_q    <= s_axis_tdata[202:171];
						pz_q    <= s_axis_tdata[234:203];
						im_q    <= s_axis_tdata[266:235];
						pf_q    <= s_axis_tdata[268:267];
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_status_q <= ST_DONE;
					res_lam_q    <= lam_q;
					res_pos_q    <= '0;
					case (act_q)
						ACT_LOAD: begin
							if (idx_ok(ia_q)) begin
								fvalid_q[IDX_W'(ia_q)] <= 1'b1;
							end
							state_q <= S_OUT;
						end
						ACT_SOLVE: begin
							if (!idx_ok(ia_q) || !idx_ok(ib_q)) begin
								res_status_q <= ST_NOT_EVAL;
								state_q      <= S_OUT;
							end else begin
								state_q <= S_RDB;
							end
						end
						ACT_READ: begin
							state_q <= idx_ok(ia_q) ? S_READ : S_OUT;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_READ: begin
					res_pos_q <= ram_rdata.pos;
					state_q   <= S_OUT;
				end
				S_RDB: begin
					row_a_q <= ram_rdata;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					// skip order: not evaluated, then zero weight
					row_b_q <= ram_rdata;
					wa_q    <= wa_w;
					wb_q    <= wb_w;
					wsum_q  <= wsum_w;
					dlt_q[0] <= 33'(signed'(row_a_q.pos[0])) - 33'(signed'(ram_rdata.pos[0]));
					dlt_q[1] <= 33'(signed'(row_a_q.pos[1])) - 33'(signed'(ram_rdata.pos[1]));
					dlt_q[2] <= 33'(signed'(row_a_q.pos[2])) - 33'(signed'(ram_rdata.pos[2]));
					sum_q   <= '0;
					k_q     <= '0;
					if (!fa_w[0] || !fb_w[0]) begin
						res_status_q <= ST_NOT_EVAL;
						state_q      <= S_OUT;
					end else if (wsum_w == 33'd0) begin
						res_status_q <= ST_ZERO_WGT;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_SQ_MUL;
					end
				end
				S_SQ_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_SQ_ACC;
				end
				S_SQ_ACC: begin
					sum_q <= sum_q + 66'(prod_q[63:0]);
					if (k_q == 2'd2) begin
						state_q <= S_DT_MUL;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_SQ_MUL;
					end
				end
				S_DT_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					dsq_q <= prod_q[63:0];
					if (sqrt_done) begin
						d_q     <= sqrt_root;
						state_q <= S_CSEL;
					end
				end
				S_CSEL: begin
					c_q    <= c_w;
					comp_q <= (c_w > 35'sd0) ? str_q : shr_q;
					if (d_q == 33'd0) begin
						res_status_q <= ST_ZERO_LEN;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_ALPHA;
					end
				end
				S_ALPHA: begin
					if (comp_q == 32'd0) begin
						alpha_q <= 32'd0;
						state_q <= S_LAM_MUL;
					end else if (!div_req.start) begin
						// zero step or quotient too large: saturate
						alpha_q <= '1;
						state_q <= S_LAM_MUL;
					end else begin
						state_q <= S_ALPHA_WAIT;
					end
				end
				S_ALPHA_WAIT: begin
					if (div_done) begin
						alpha_q <= div_quo;
						state_q <= S_LAM_MUL;
					end
				end
				S_LAM_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_LAM_USE;
				end
				S_LAM_USE: begin
					nneg_q  <= num_w[50];
					nmag_q  <= num_w[50] ? 51'(-num_w) : num_w;
					den_q   <= 34'(wsum_q) + 34'(alpha_q);
					state_q <= S_DL_GO;
				end
				S_DL_GO: begin
					qbig_q  <= !div_req.start;
					state_q <= div_req.start ? S_DL_WAIT : S_DL_FIX;
				end
				S_DL_WAIT: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= S_DL_FIX;
					end
				end
				S_DL_FIX: begin
					dl_q    <= dl_w;
					k_q     <= '0;
					state_q <= S_CM_MUL;
				end
				S_CM_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_CM_GO;
				end
				S_CM_GO: begin
					state_q <= S_CM_WAIT;
				end
				S_CM_WAIT: begin
					if (div_done) begin
						corr_q  <= div_quo;
						state_q <= S_MV_A;
					end
				end
				S_MV_A: begin
					prod_q  <= mul_p;
					state_q <= S_MV_AU;
				end
				S_MV_AU: begin
					row_a_q.pos[k_q] <= sat32(new_pos_w);
					state_q          <= S_MV_B;
				end
				S_MV_B: begin
					prod_q  <= mul_p;
					state_q <= S_MV_BU;
				end
				S_MV_BU: begin
					row_b_q.pos[k_q] <= sat32(new_pos_w);
					if (k_q == 2'd2) begin
						state_q <= S_WR_A;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_CM_MUL;
					end
				end
				S_WR_A: begin
					state_q <= S_WR_B;
				end
				S_WR_B: begin
					res_status_q <= ST_SOLVED;
					res_lam_q    <= new_lam_w;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					// output register frees up when the pending beat leaves
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_data_q   <= {res_pos_q, res_lam_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_status_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------

	// one item at a time: no second beat right after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in flight");

	// only a read returns a position, and a read always reports done
	a_pos_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata[127:32] == '0)
		else $error("position on a non-read result");

	// the divider only finishes while the sequencer waits for it
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_ALPHA_WAIT || state_q == S_DL_WAIT
		          || state_q == S_CM_WAIT)
		else $error("divider result dropped");

	// root finishes only while waited for
	a_sqrt_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == S_SQRT)
		else $error("square root result dropped");

endmodule

// ----- design/xpbd_ram.sv -----
`timescale 1ns / 1ps

module xpbd_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- design/xpbd_div.sv -----
`timescale 1ns / 1ps

module xpbd_div
	import xpbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [31:0] quo
);

	logic [63:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] quo_q;
	logic [63:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [64:0] trial;
	logic        ge;
	logic [64:0] diff;

	// restoring step, one quotient bit a cycle
	assign trial = {rem_q, low_q[31]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.rem_init;
				low_q  <= req.low;
				div_q  <= req.divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[63:0] : trial[63:0];
				low_q <= {low_q[30:0], 1'b0};
				quo_q <= {quo_q[30:0], ge};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- design/xpbd_isqrt.sv -----
`timescale 1ns / 1ps

module xpbd_isqrt
	import xpbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] n,
	output logic        done,
	output logic [32:0] root
);

	logic [65:0] n_q;
	logic [35:0] rem_q;
	logic [32:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [36:0] r4;
	logic [36:0] trial;
	logic        ge;
	logic [36:0] diff;

	// two radicand bits a step, one root bit a step
	assign r4    = {rem_q[34:0], n_q[65:64]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = r4 >= trial;
	assign diff  = r4 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q    <= n;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				n_q    <= {n_q[63:0], 2'b00};
				rem_q  <= ge ? diff[35:0] : r4[35:0];
				root_q <= {root_q[31:0], ge};
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import xpbd_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 step_time_we;
	logic [31:0]          step_time_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [1:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [2:0]           m_axis_tuser;

	typedef struct {
		logic [1:0]  action;
		logic [5:0]  ia;
		logic [5:0]  ib;
		logic [30:0] rest;
		logic [31:0] stretch;
		logic [31:0] shrink;
		logic [31:0] lambda;
		logic [31:0] px, py, pz;
		logic [31:0] mass;
		logic [1:0]  flags;
	} item_t;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] lambda;
		logic [31:0] ox, oy, oz;
	} outcome_t;

	// shadow of the particle table and step register
	longint      pos_tbl [64][3];
	longint      mass_tbl [64];
	logic [1:0]  flag_tbl [64];
	bit          loaded [64];
	logic [31:0] dt_reg;

	outcome_t    outcome_q[$];
	int          errors;
	bit          long_hold;
	int          sent;

	// gaps between bursts on the sending side
	int          burst_left;

	xpbd_distance_constraint_solver_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_time_we   (step_time_we),
		.step_time_wdata(step_time_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic longint sat_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint floor_asr16(longint v);
		return v >>> 16;
	endfunction

	// floor(comp * 2^52 / dt^2) held in 32 bits, 128-bit math for headroom
	function automatic longint alpha_calc(logic [31:0] comp);
		logic [127:0] dsq;
		logic [127:0] q;
		dsq = {96'd0, dt_reg} * {96'd0, dt_reg};
		if (comp == 0) return 0;
		if (dsq == 0) return 64'hffffffff;
		q = ({96'd0, comp} << 52) / dsq;
		if (q > 128'hffffffff) return 64'hffffffff;
		return longint'(q[31:0]);
	endfunction

	function automatic longint nudge(longint p, longint delta, longint dl, longint d,
			longint w, bit add);
		logic [127:0] corr;
		logic [127:0] mv;
		longint       ad;
		longint       al;
		bit           neg;
		ad = delta < 0 ? -delta : delta;
		al = dl < 0 ? -dl : dl;
		corr = ({64'd0, ad} * {64'd0, al}) / d;
		mv = (corr * w) >> 16;
		neg = ((delta < 0) != (dl < 0)) != !add;
		if (mv == 0) return p;
		return sat_s32(neg ? p - longint'(mv) : p + longint'(mv));
	endfunction

	// exact floor of the Euclidean length via 128-bit integer root
	function automatic longint length_of(longint dx, longint dy, longint dz);
		logic [127:0] n;
		logic [127:0] r;
		logic [127:0] b;
		n = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
		r = 0;
		b = 128'd1 << 126;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic logic [2:0] constraint_solve(item_t it, ref longint lam);
		longint wa, wb, wsum, dx, dy, dz, d, c, alpha, num, dl;
		longint unsigned q;
		logic [31:0] comp;
		int a, b;
		a = it.ia;
		b = it.ib;
		if (!flag_tbl[a][0] || !flag_tbl[b][0]) return ST_NOT_EVAL;
		wa = flag_tbl[a][1] ? mass_tbl[a] : 0;
		wb = flag_tbl[b][1] ? mass_tbl[b] : 0;
		wsum = wa + wb;
		if (wsum == 0) return ST_ZERO_WGT;
		dx = pos_tbl[a][0] - pos_tbl[b][0];
		dy = pos_tbl[a][1] - pos_tbl[b][1];
		dz = pos_tbl[a][2] - pos_tbl[b][2];
		d = length_of(dx, dy, dz);
		if (d == 0) return ST_ZERO_LEN;
		c = d - longint'(it.rest);
		comp = c > 0 ? it.stretch : it.shrink;
		alpha = alpha_calc(comp);
		num = -c - floor_asr16(alpha * lam);
		q = (unsigned'(num < 0 ? -num : num) << 16) / unsigned'(wsum + alpha);
		if (num < 0) dl = q > 64'sd2147483648 ? -64'sd2147483648 : -q;
		else dl = q > 64'sd2147483647 ? 64'sd2147483647 : q;
		pos_tbl[a][0] = nudge(pos_tbl[a][0], dx, dl, d, wa, 1'b1);
		pos_tbl[a][1] = nudge(pos_tbl[a][1], dy, dl, d, wa, 1'b1);
		pos_tbl[a][2] = nudge(pos_tbl[a][2], dz, dl, d, wa, 1'b1);
		pos_tbl[b][0] = nudge(pos_tbl[b][0], dx, dl, d, wb, 1'b0);
		pos_tbl[b][1] = nudge(pos_tbl[b][1], dy, dl, d, wb, 1'b0);
		pos_tbl[b][2] = nudge(pos_tbl[b][2], dz, dl, d, wb, 1'b0);
		lam = sat_s32(lam + dl);
		return ST_SOLVED;
	endfunction

	// predicted result beat for one accepted item
	function automatic outcome_t particle_predict(item_t it);
		outcome_t o;
		longint   lam;
		lam = longint'($signed(it.lambda));
		o.status = ST_DONE;
		o.ox = 0;
		o.oy = 0;
		o.oz = 0;
		case (it.action)
			ACT_LOAD: begin
				pos_tbl[it.ia][0] = longint'($signed(it.px));
				pos_tbl[it.ia][1] = longint'($signed(it.py));
				pos_tbl[it.ia][2] = longint'($signed(it.pz));
				mass_tbl[it.ia] = longint'(it.mass);
				flag_tbl[it.ia] = it.flags;
				loaded[it.ia] = 1'b1;
			end
			ACT_SOLVE: o.status = constraint_solve(it, lam);
			ACT_READ: begin
				o.ox = pos_tbl[it.ia][0][31:0];
				o.oy = pos_tbl[it.ia][1][31:0];
				o.oz = pos_tbl[it.ia][2][31:0];
			end
			default: ;
		endcase
		o.lambda = lam[31:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// one item, sent in bursts with random gaps between them
	task automatic send_item(item_t it);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.action;
		s_axis_tdata  <= {3'd0, it.flags, it.mass, it.pz, it.py, it.px, it.lambda,
			it.shrink, it.stretch, it.rest, it.ib, it.ia};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		outcome_q.push_back(particle_predict(it));
		burst_left--;
		sent++;
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_step(logic [31:0] v);
		drain();
		step_time_we    <= 1'b1;
		step_time_wdata <= v;
		@(posedge clk);
		step_time_we    <= 1'b0;
		dt_reg = v;
	endtask

	function automatic item_t blank_item(logic [1:0] act);
		item_t it;
		it = '{default: '0};
		it.action = act;
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			default: return $urandom_range(0, 32'h00200000) - 32'h00100000;
		endcase
	endfunction

	function automatic item_t rand_load(int idx);
		item_t it;
		it = blank_item(ACT_LOAD);
		it.ia = 6'(idx);
		it.px = rand_coord();
		it.py = rand_coord();
		it.pz = rand_coord();
		it.mass = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h30000);
		it.flags = 2'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 3);
		it.lambda = $urandom();
		it.ib = 6'($urandom());
		return it;
	endfunction

	// random solves and reads only touch loaded particles
	function automatic int pick_loaded();
		int k;
		k = $urandom_range(0, 63);
		while (!loaded[k]) k = $urandom_range(0, 63);
		return k;
	endfunction

	function automatic item_t rand_solve();
		item_t it;
		it = blank_item(ACT_SOLVE);
		it.ia = 6'(pick_loaded());
		it.ib = ($urandom_range(0, 15) == 0) ? it.ia : 6'(pick_loaded());
		it.rest = 31'(($urandom_range(0, 7) == 0) ? $urandom()
			: $urandom_range(0, 32'h200000));
		it.stretch = ($urandom_range(0, 2) == 0) ? 0 : $urandom() >> $urandom_range(0, 31);
		it.shrink = ($urandom_range(0, 2) == 0) ? 0 : $urandom() >> $urandom_range(0, 31);
		it.lambda = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h20000)
			- 32'h10000;
		it.px = $urandom();
		it.mass = $urandom();
		it.flags = 2'($urandom());
		return it;
	endfunction

	function automatic item_t rand_read();
		item_t it;
		it = rand_solve();
		it.action = ACT_READ;
		return it;
	endfunction

	// result checker with its own stall pattern
	always @(posedge clk) begin
		outcome_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("unexpected result beat", m_axis_tdata[31:0], 32'd0);
			end else begin
				want = outcome_q.pop_front();
				if (m_axis_tuser !== want.status)
					report_mismatch("status", m_axis_tuser, want.status);
				if (m_axis_tdata[31:0] !== want.lambda)
					report_mismatch("new_lambda", m_axis_tdata[31:0], want.lambda);
				if (m_axis_tdata[63:32] !== want.ox)
					report_mismatch("out_x", m_axis_tdata[63:32], want.ox);
				if (m_axis_tdata[95:64] !== want.oy)
					report_mismatch("out_y", m_axis_tdata[95:64], want.oy);
				if (m_axis_tdata[127:96] !== want.oz)
					report_mismatch("out_z", m_axis_tdata[127:96], want.oz);
			end
		end
	end

	initial begin
		int phase;
		m_axis_tready = 1'b0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold = 1'b0;
			end
			phase++;
			// alternating stretches: free flow, then a random stall pattern
			if ((phase / 200) % 2 == 0) m_axis_tready <= 1'b1;
			else m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic test_load_read_extremes;
		item_t it;
		for (int k = 0; k < 4; k++) begin
			it = blank_item(ACT_LOAD);
			it.ia = (k == 3) ? 6'd63 : 6'(k);
			it.px = (k == 0) ? 32'h7fffffff : 32'h80000000 + k;
			it.py = k << 16;
			it.pz = (k == 1) ? 32'hffffffff : 0;
			it.mass = (k == 2) ? 32'hffffffff : 32'h10000;
			it.flags = (k == 3) ? 2'd1 : 2'd3;
			it.lambda = 32'hffffffff;
			send_item(it);
			it.action = ACT_READ;
			send_item(it);
		end
		it = blank_item(2'd3);
		it.lambda = 32'h80000000;
		send_item(it);
	endtask

	task automatic test_skip_cases;
		item_t it;
		// unloaded partner is not evaluated
		it = blank_item(ACT_SOLVE);
		it.ia = 0;
		it.ib = 10;
		it.lambda = 32'h1234;
		send_item(it);
		// same particle twice gives zero length
		it.ib = 0;
		send_item(it);
		// pinned with evaluate only: zero weight
		it = blank_item(ACT_LOAD);
		it.ia = 10;
		it.flags = 2'd1;
		send_item(it);
		it.ia = 11;
		it.px = 32'h10000;
		send_item(it);
		it = blank_item(ACT_SOLVE);
		it.ia = 10;
		it.ib = 11;
		send_item(it);
		// two loaded, one not evaluated
		it = blank_item(ACT_LOAD);
		it.ia = 12;
		it.flags = 2'd2;
		it.mass = 32'h10000;
		send_item(it);
		it = blank_item(ACT_SOLVE);
		it.ia = 1;
		it.ib = 12;
		send_item(it);
	endtask

	task automatic test_solve_directed;
		item_t it;
		it = blank_item(ACT_SOLVE);
		it.ia = 0;
		it.ib = 1;
		it.rest = 31'h7fffffff;
		it.shrink = 32'hffffffff;
		it.lambda = 32'h7fffffff;
		send_item(it);
		it.ib = 2;
		it.rest = 0;
		it.stretch = 32'h10000000;
		it.lambda = 32'h80000000;
		send_item(it);
		it.ia = 1;
		it.action = ACT_READ;
		send_item(it);
	endtask

	task automatic test_random_mix(int count);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0, 1: send_item(rand_load($urandom_range(0, 63)));
				2: send_item(rand_read());
				default: send_item(rand_solve());
			endcase
		end
	endtask

	task automatic test_backpressure;
		long_hold = 1'b1;
		test_random_mix(20);
	endtask

	task automatic test_step_sweep;
		set_step(32'd0);
		test_random_mix(100);
		set_step(32'hffffffff);
		test_random_mix(100);
		set_step(32'd1);
		test_random_mix(60);
		set_step($urandom());
		test_random_mix(140);
	endtask

	initial begin
		errors = 0;
		sent = 0;
		burst_left = 0;
		long_hold = 1'b0;
		dt_reg = 32'd71582788;
		for (int k = 0; k < 64; k++) begin
			flag_tbl[k] = 2'd0;
			loaded[k] = 1'b0;
			mass_tbl[k] = 0;
			for (int j = 0; j < 3; j++) pos_tbl[k][j] = 0;
		end
		arst_n = 1'b0;
		step_time_we = 1'b0;
		step_time_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_read_extremes();
		test_skip_cases();
		test_solve_directed();
		// fill the table so every solve has loaded rows
		for (int k = 0; k < 64; k++) send_item(rand_load(k));
		test_random_mix(350);
		test_backpressure();
		test_step_sweep();
		test_random_mix(100);

		drain();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/xpbd_pkg.sv
design/xpbd_ram.sv
design/xpbd_div.sv
design/xpbd_isqrt.sv
design/xpbd_distance_constraint_solver_unit.sv
bench/tb_top.sv
